### design/ctt_pkg.sv
// ----------------------------------------------------------------------------
// ctt_pkg: shared types and constants of the clock time text parser
// Holds the parser state word, the result word and their codes.
// ----------------------------------------------------------------------------
`default_nettype none

package ctt_pkg;

    // field and limit widths
    localparam int unsigned ACC_W  = 7;
    localparam int unsigned LEN_W  = 16;
    localparam int unsigned HOUR_W = 5;
    localparam int unsigned MIN_W  = 6;

    // saturation points and field limits
    localparam logic [ACC_W-1:0]  ACC_MAX  = 7'd127;
    localparam logic [LEN_W-1:0]  LEN_MAX  = 16'hFFFF;
    localparam logic [ACC_W-1:0]  HOUR_LIM = 7'd24;
    localparam logic [ACC_W-1:0]  MIN_LIM  = 7'd60;
    localparam logic [ACC_W-1:0]  NOON     = 7'd12;

    // parse phase, one-hot
    typedef enum logic [18:0] {
        PH_HOUR_WS   = 19'h00001,
        PH_HOUR_SIGN = 19'h00002,
        PH_HOUR_DIG  = 19'h00004,
        PH_HOUR_POST = 19'h00008,
        PH_MIN_WS    = 19'h00010,
        PH_MIN_SIGN  = 19'h00020,
        PH_MIN_DIG   = 19'h00040,
        PH_MIN_POST  = 19'h00080,
        PH_SEC_WS    = 19'h00100,
        PH_SEC_SIGN  = 19'h00200,
        PH_SEC_DIG   = 19'h00400,
        PH_AP_LEAD   = 19'h00800,
        PH_AP_M      = 19'h01000,
        PH_AP_END    = 19'h02000,
        PH_AP_WS     = 19'h04000,
        PH_TL_LEAD   = 19'h08000,
        PH_TL_M      = 19'h10000,
        PH_TL_END    = 19'h20000,
        PH_TL_WS     = 19'h40000
    } t_phase;

    typedef enum logic [1:0] {
        MER_NONE = 2'd0,
        MER_AM   = 2'd1,
        MER_PM   = 2'd2
    } t_meridiem;

    typedef enum logic [1:0] {
        VER_UNDECIDED = 2'd0,
        VER_ACCEPT    = 2'd1,
        VER_REJECT    = 2'd2
    } t_verdict;

    // running parse state
    typedef struct packed {
        t_phase           phase;
        logic [ACC_W-1:0] hour_acc;
        logic [ACC_W-1:0] minute_acc;
        logic [ACC_W-1:0] second_acc;
        logic             minus_seen;
        t_meridiem        meridiem;
        logic [LEN_W-1:0] byte_count;
        logic [LEN_W-1:0] commit_len;
        t_verdict         verdict;
    } t_parse;

    // one result word
    typedef struct packed {
        logic              ok;
        logic [HOUR_W-1:0] hour;
        logic [MIN_W-1:0]  minute;
        logic [MIN_W-1:0]  second;
        logic [LEN_W-1:0]  used_length;
    } t_result;

    localparam t_parse PARSE_RESET = '{
        phase:      PH_HOUR_WS,
        hour_acc:   '0,
        minute_acc: '0,
        second_acc: '0,
        minus_seen: 1'b0,
        meridiem:   MER_NONE,
        byte_count: '0,
        commit_len: '0,
        verdict:    VER_UNDECIDED
    };

endpackage

`default_nettype wire

### design/ctt_step.sv
// ----------------------------------------------------------------------------
// ctt_step: next-state logic of the clock time text parser
// Applies one byte to the parse state, including the re-examination of the
// same byte in a following phase, and forms the result word at a zero byte.
// ----------------------------------------------------------------------------
`default_nettype none

module ctt_step (
    input  wire ctt_pkg::t_parse  i_state,
    input  wire logic [7:0]       i_ch,
    output ctt_pkg::t_parse       o_state,
    output ctt_pkg::t_result      o_result
);

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_D0    = 8'h30;
    localparam logic [7:0] CH_D9    = 8'h39;
    localparam logic [7:0] CH_A_UP  = 8'h41;
    localparam logic [7:0] CH_Z_UP  = 8'h5A;
    localparam logic [7:0] CH_A_LO  = 8'h61;
    localparam logic [7:0] CH_Z_LO  = 8'h7A;
    localparam logic [7:0] CH_P_UP  = 8'h50;
    localparam logic [7:0] CH_P_LO  = 8'h70;
    localparam logic [7:0] CH_M_UP  = 8'h4D;
    localparam logic [7:0] CH_M_LO  = 8'h6D;

    localparam logic [1:0] G_HOUR = 2'd0;
    localparam logic [1:0] G_MIN  = 2'd1;
    localparam logic [1:0] G_SEC  = 2'd2;

    typedef struct packed {
        ctt_pkg::t_parse s;
        logic            again;
    } t_adv;

    function automatic logic is_ws(input logic [7:0] c);
        return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic logic is_dig(input logic [7:0] c);
        return (c >= CH_D0) && (c <= CH_D9);
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= CH_A_LO && c <= CH_Z_LO) || (c >= CH_A_UP && c <= CH_Z_UP);
    endfunction

    // field group of a number phase
    function automatic logic [1:0] grp_of(input ctt_pkg::t_phase p);
        logic [1:0] g;
        g = G_SEC;
        if (p == ctt_pkg::PH_HOUR_WS || p == ctt_pkg::PH_HOUR_SIGN ||
            p == ctt_pkg::PH_HOUR_DIG) begin
            g = G_HOUR;
        end else if (p == ctt_pkg::PH_MIN_WS || p == ctt_pkg::PH_MIN_SIGN ||
                     p == ctt_pkg::PH_MIN_DIG) begin
            g = G_MIN;
        end
        return g;
    endfunction

    function automatic ctt_pkg::t_phase sign_ph(input logic [1:0] g);
        ctt_pkg::t_phase p;
        p = ctt_pkg::PH_SEC_SIGN;
        if (g == G_HOUR) begin
            p = ctt_pkg::PH_HOUR_SIGN;
        end else if (g == G_MIN) begin
            p = ctt_pkg::PH_MIN_SIGN;
        end
        return p;
    endfunction

    function automatic ctt_pkg::t_phase dig_ph(input logic [1:0] g);
        ctt_pkg::t_phase p;
        p = ctt_pkg::PH_SEC_DIG;
        if (g == G_HOUR) begin
            p = ctt_pkg::PH_HOUR_DIG;
        end else if (g == G_MIN) begin
            p = ctt_pkg::PH_MIN_DIG;
        end
        return p;
    endfunction

    function automatic logic [ctt_pkg::ACC_W-1:0] get_acc(input ctt_pkg::t_parse s,
                                                          input logic [1:0] g);
        logic [ctt_pkg::ACC_W-1:0] a;
        a = s.second_acc;
        if (g == G_HOUR) begin
            a = s.hour_acc;
        end else if (g == G_MIN) begin
            a = s.minute_acc;
        end
        return a;
    endfunction

    function automatic ctt_pkg::t_parse put_acc(input ctt_pkg::t_parse s,
                                                input logic [1:0] g,
                                                input logic [ctt_pkg::ACC_W-1:0] v);
        ctt_pkg::t_parse r;
        r = s;
        if (g == G_HOUR) begin
            r.hour_acc = v;
        end else if (g == G_MIN) begin
            r.minute_acc = v;
        end else begin
            r.second_acc = v;
        end
        return r;
    endfunction

    // acc * 10 + digit, saturating
    function automatic logic [ctt_pkg::ACC_W-1:0] mul10_sat(
        input logic [ctt_pkg::ACC_W-1:0] a, input logic [3:0] d);
        logic [ctt_pkg::ACC_W+3:0] v;
        v = {a, 3'b000} + {2'b00, a, 1'b0} + {{ctt_pkg::ACC_W{1'b0}}, d};
        return (v > {4'b0000, ctt_pkg::ACC_MAX}) ? ctt_pkg::ACC_MAX
                                                 : v[ctt_pkg::ACC_W-1:0];
    endfunction

    function automatic logic ampm_hour(input ctt_pkg::t_parse s);
        return (s.hour_acc != '0) && (s.hour_acc <= ctt_pkg::NOON);
    endfunction

    function automatic ctt_pkg::t_parse do_reject(input ctt_pkg::t_parse s);
        ctt_pkg::t_parse r;
        r = s;
        r.verdict  = ctt_pkg::VER_REJECT;
        r.meridiem = ctt_pkg::MER_NONE;
        return r;
    endfunction

    function automatic ctt_pkg::t_parse do_accept(input ctt_pkg::t_parse s,
                                                  input logic [ctt_pkg::LEN_W-1:0] len);
        ctt_pkg::t_parse r;
        r = s;
        r.verdict    = ctt_pkg::VER_ACCEPT;
        r.commit_len = len;
        return r;
    endfunction

    // one parse step; again asks for the same byte in the new phase
    function automatic t_adv adv_one(input ctt_pkg::t_parse s, input logic [7:0] c);
        t_adv                      r;
        logic [1:0]                g;
        logic [ctt_pkg::ACC_W-1:0] acc;
        logic [ctt_pkg::ACC_W-1:0] lim;
        logic [ctt_pkg::ACC_W-1:0] dval;
        logic                      tail;
        logic                      fail;
        r.s     = s;
        r.again = 1'b0;
        g       = grp_of(s.phase);
        acc     = get_acc(s, g);
        lim     = (g == G_HOUR) ? ctt_pkg::HOUR_LIM : ctt_pkg::MIN_LIM;
        dval    = {3'b000, c[3:0]};
        tail    = (s.phase == ctt_pkg::PH_TL_LEAD) || (s.phase == ctt_pkg::PH_TL_M) ||
                  (s.phase == ctt_pkg::PH_TL_END)  || (s.phase == ctt_pkg::PH_TL_WS);
        fail    = 1'b0;
        unique case (s.phase)
            // leading whitespace and sign of a number
            ctt_pkg::PH_HOUR_WS, ctt_pkg::PH_MIN_WS, ctt_pkg::PH_SEC_WS: begin
                if (is_ws(c)) begin
                    r.s = s;
                end else if (c == CH_PLUS || c == CH_MINUS) begin
                    r.s.minus_seen = (c == CH_MINUS);
                    r.s.phase      = sign_ph(g);
                end else if (is_dig(c)) begin
                    r.s       = put_acc(s, g, dval);
                    r.s.phase = dig_ph(g);
                end else begin
                    r.s = do_reject(s);
                end
            end
            // first digit after a sign
            ctt_pkg::PH_HOUR_SIGN, ctt_pkg::PH_MIN_SIGN, ctt_pkg::PH_SEC_SIGN: begin
                if (is_dig(c)) begin
                    r.s       = put_acc(s, g, dval);
                    r.s.phase = dig_ph(g);
                end else begin
                    r.s = do_reject(s);
                end
            end
            // digit run and range check at its end
            ctt_pkg::PH_HOUR_DIG, ctt_pkg::PH_MIN_DIG, ctt_pkg::PH_SEC_DIG: begin
                if (is_dig(c)) begin
                    r.s = put_acc(s, g, mul10_sat(acc, c[3:0]));
                end else if ((s.minus_seen && acc != '0) || acc >= lim) begin
                    r.s = do_reject(s);
                end else if (g == G_HOUR) begin
                    r.s.phase = ctt_pkg::PH_HOUR_POST;
                    r.again   = 1'b1;
                end else if (g == G_MIN) begin
                    r.s.phase = ctt_pkg::PH_MIN_POST;
                    r.again   = 1'b1;
                end else begin
                    r.s.commit_len = s.byte_count;
                    if (ampm_hour(s)) begin
                        r.s.phase = ctt_pkg::PH_TL_LEAD;
                        r.again   = 1'b1;
                    end else begin
                        r.s = do_accept(r.s, s.byte_count);
                    end
                end
            end
            // after the hour
            ctt_pkg::PH_HOUR_POST: begin
                if (is_ws(c)) begin
                    r.s = s;
                end else if (c == CH_COLON) begin
                    r.s.minus_seen = 1'b0;
                    r.s.phase      = ctt_pkg::PH_MIN_WS;
                end else if (ampm_hour(s)) begin
                    r.s.phase = ctt_pkg::PH_AP_LEAD;
                    r.again   = 1'b1;
                end else begin
                    r.s = do_reject(s);
                end
            end
            // after the minute
            ctt_pkg::PH_MIN_POST: begin
                if (!is_ws(c)) begin
                    r.s.commit_len = s.byte_count;
                    if (c == CH_COLON) begin
                        r.s.minus_seen = 1'b0;
                        r.s.phase      = ctt_pkg::PH_SEC_WS;
                    end else if (ampm_hour(s)) begin
                        r.s.phase = ctt_pkg::PH_TL_LEAD;
                        r.again   = 1'b1;
                    end else begin
                        r.s = do_accept(r.s, s.byte_count);
                    end
                end
            end
            // suffix letter a or p
            ctt_pkg::PH_AP_LEAD, ctt_pkg::PH_TL_LEAD: begin
                if (is_ws(c)) begin
                    r.s = s;
                end else if (c == CH_A_LO || c == CH_A_UP) begin
                    r.s.meridiem = ctt_pkg::MER_AM;
                    r.s.phase    = tail ? ctt_pkg::PH_TL_M : ctt_pkg::PH_AP_M;
                end else if (c == CH_P_LO || c == CH_P_UP) begin
                    r.s.meridiem = ctt_pkg::MER_PM;
                    r.s.phase    = tail ? ctt_pkg::PH_TL_M : ctt_pkg::PH_AP_M;
                end else begin
                    fail = 1'b1;
                end
            end
            // optional m, or end of string
            ctt_pkg::PH_AP_M, ctt_pkg::PH_TL_M: begin
                if (c == CH_NUL) begin
                    r.s = do_accept(s, s.byte_count);
                end else if (c == CH_M_LO || c == CH_M_UP) begin
                    r.s.phase = tail ? ctt_pkg::PH_TL_END : ctt_pkg::PH_AP_END;
                end else begin
                    fail = 1'b1;
                end
            end
            // no letter may follow the suffix
            ctt_pkg::PH_AP_END, ctt_pkg::PH_TL_END: begin
                if (is_alpha(c)) begin
                    fail = 1'b1;
                end else begin
                    r.s.phase = tail ? ctt_pkg::PH_TL_WS : ctt_pkg::PH_AP_WS;
                    r.again   = 1'b1;
                end
            end
            // whitespace after the suffix
            ctt_pkg::PH_AP_WS, ctt_pkg::PH_TL_WS: begin
                if (!is_ws(c)) begin
                    r.s = do_accept(s, s.byte_count);
                end
            end
            default: begin
                r.s = s;
            end
        endcase
        // bad suffix: keep the time after minutes or seconds, else fail
        if (fail) begin
            r.s.meridiem = ctt_pkg::MER_NONE;
            if (tail) begin
                r.s = do_accept(r.s, s.commit_len);
            end else begin
                r.s = do_reject(r.s);
            end
        end
        return r;
    endfunction

    t_adv                   a1, a2, a3;
    ctt_pkg::t_parse        st1, st2, st3;
    logic                   go2, go3;
    logic [ctt_pkg::HOUR_W-1:0] hour_adj;

    // up to three passes over the same byte
    always_comb begin
        a1  = adv_one(i_state, i_ch);
        st1 = (i_state.verdict == ctt_pkg::VER_UNDECIDED) ? a1.s : i_state;
        go2 = (i_state.verdict == ctt_pkg::VER_UNDECIDED) && a1.again &&
              (st1.verdict == ctt_pkg::VER_UNDECIDED);
        a2  = adv_one(st1, i_ch);
        st2 = go2 ? a2.s : st1;
        go3 = go2 && a2.again && (st2.verdict == ctt_pkg::VER_UNDECIDED);
        a3  = adv_one(st2, i_ch);
        st3 = go3 ? a3.s : st2;
    end

    // 24-hour adjustment
    always_comb begin
        hour_adj = st3.hour_acc[ctt_pkg::HOUR_W-1:0];
        if (st3.meridiem == ctt_pkg::MER_AM && st3.hour_acc == ctt_pkg::NOON) begin
            hour_adj = '0;
        end else if (st3.meridiem == ctt_pkg::MER_PM && st3.hour_acc != ctt_pkg::NOON) begin
            hour_adj = st3.hour_acc[ctt_pkg::HOUR_W-1:0] + ctt_pkg::NOON[ctt_pkg::HOUR_W-1:0];
        end
    end

    // result word and next state
    always_comb begin
        o_result = '0;
        if (st3.verdict == ctt_pkg::VER_ACCEPT) begin
            o_result.ok          = 1'b1;
            o_result.hour        = hour_adj;
            o_result.minute      = st3.minute_acc[ctt_pkg::MIN_W-1:0];
            o_result.second      = st3.second_acc[ctt_pkg::MIN_W-1:0];
            o_result.used_length = st3.commit_len;
        end
        o_state = st3;
        if (i_state.byte_count != ctt_pkg::LEN_MAX) begin
            o_state.byte_count = i_state.byte_count + 1'b1;
        end
        if (i_ch == CH_NUL) begin
            o_state = ctt_pkg::PARSE_RESET;
        end
    end

endmodule

`default_nettype wire

### design/clock_time_text_parser.sv
// ----------------------------------------------------------------------------
// clock_time_text_parser: streaming parser for clock time text
// Reads one byte per word and gives one result word at each zero byte.
// ----------------------------------------------------------------------------
// The block takes one byte per cycle while o_stall is low: each byte lands
// in an input register and goes through the parse logic, and a zero byte
// loads the output register with ok, hour (24-hour form), minute, second and
// the number of bytes the time text used. o_stall rises only when a zero
// byte is waiting while the previous result is still held by i_stall; the
// input register holds its byte and no other bytes move during that time.
// ----------------------------------------------------------------------------
`default_nettype none

module clock_time_text_parser (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [7:0]  i_ch,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic             o_ok,
    output logic [4:0]       o_hour,
    output logic [5:0]       o_minute,
    output logic [5:0]       o_second,
    output logic [15:0]      o_used_length
);

    logic             r_in_valid;
    logic [7:0]       r_ch;
    ctt_pkg::t_parse  r_state;
    logic             r_out_valid;
    ctt_pkg::t_result r_res;

    ctt_pkg::t_parse  n_state;
    ctt_pkg::t_result n_res;
    logic             advance;
    logic             is_end;

    // parse logic
    ctt_step u_step (
        .i_state  (r_state),
        .i_ch     (r_ch),
        .o_state  (n_state),
        .o_result (n_res)
    );

    // a byte moves on unless it ends a string and the result slot is busy
    assign is_end  = (r_ch == 8'h00);
    assign advance = r_in_valid && (!is_end || !r_out_valid || !i_stall);
    assign o_stall = r_in_valid && !advance;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
        if (i_valid && !o_stall) begin
            r_ch <= i_ch;
        end
    end

    // parse state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ctt_pkg::PARSE_RESET;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
            if (advance && is_end) begin
                r_out_valid <= 1'b1;
            end
        end
        if (advance && is_end) begin
            r_res <= n_res;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_ok          = r_res.ok;
    assign o_hour        = r_res.hour;
    assign o_minute      = r_res.minute;
    assign o_second      = r_res.second;
    assign o_used_length = r_res.used_length;

`ifndef SYNTHESIS
    // a failed parse gives all-zero fields
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_ok |-> o_hour == '0 && o_minute == '0 && o_second == '0 &&
                             o_used_length == '0)
        else $error("failed result carries nonzero fields");

    // an accepted time is in range
    a_ok_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_ok |-> o_hour < 5'd24 && o_minute < 6'd60 && o_second < 6'd60)
        else $error("accepted time out of range");

    // the parser starts over after a string ends
    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && is_end |=> r_state == ctt_pkg::PARSE_RESET)
        else $error("parse state not cleared after end of string");

    // input stalls only behind a held result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall && is_end)
        else $error("input stalled without a held result");
`endif

endmodule

`default_nettype wire

### verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench for the clock time text parser
// Streams time strings one byte per word into the parser, directed rows
// first and random strings after, and checks every result word against a
// cycle-free model of the parse. Both sides idle and stall at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;

    localparam int RAND_BYTES  = 1950;
    localparam int HOLD_CYCLES = 300;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int AP_BASE     = $clog2(ctt_pkg::PH_AP_LEAD);
    localparam int TL_BASE     = $clog2(ctt_pkg::PH_TL_LEAD);
    localparam logic [7:0] END_BYTE = 8'h00;
    localparam ctt_pkg::t_result NO_TIME = '0;

    typedef struct {
        string            text;
        int               pad;
        bit               typed;
        ctt_pkg::t_result want;
    } t_dir_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic [7:0]  i_ch = 8'h00;
    logic        i_stall = 1'b0;
    logic        o_stall;
    logic        o_valid;
    logic        o_ok;
    logic [4:0]  o_hour;
    logic [5:0]  o_minute;
    logic [5:0]  o_second;
    logic [15:0] o_used_length;

    ctt_pkg::t_parse  ps = ctt_pkg::PARSE_RESET;
    ctt_pkg::t_result pending_times[$];
    logic [7:0]       txt[$];
    t_dir_row         dir_rows[$];
    int unsigned      mismatch_cnt = 0;
    int unsigned      cycle_cnt = 0;
    bit               hold_req = 1'b0;

    string suffix_forms [12] = '{"am", "pm", "AM", "PM", "aM", "a", "p", "amx",
                                 "PMq", "a ", "p.", "pm7"};

    clock_time_text_parser dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_ch          (i_ch),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_ok          (o_ok),
        .o_hour        (o_hour),
        .o_minute      (o_minute),
        .o_second      (o_second),
        .o_used_length (o_used_length)
    );

    always #6 i_clk = ~i_clk;

    // run limit
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d results pending", $time, pending_times.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // character classes
    function automatic bit is_ws(input logic [7:0] c);
        return c == 8'd32 || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic bit is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit is_alpha(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic int phase_idx(input ctt_pkg::t_phase p);
        int i;
        int n;
        n = 0;
        for (i = 0; i < $bits(ctt_pkg::t_phase); i++)
            if (p[i]) n = i;
        return n;
    endfunction

    // number accumulators by field: hour, minute, second
    function automatic logic [6:0] acc_of(input int g);
        if (g == 0) return ps.hour_acc;
        if (g == 1) return ps.minute_acc;
        return ps.second_acc;
    endfunction

    task automatic set_acc(input int g, input logic [6:0] v);
        if (g == 0) ps.hour_acc = v;
        else if (g == 1) ps.minute_acc = v;
        else ps.second_acc = v;
    endtask

    function automatic bit ampm_hour();
        return ps.hour_acc >= 7'd1 && ps.hour_acc <= ctt_pkg::NOON;
    endfunction

    task automatic take_time(input logic [15:0] len);
        ps.verdict = ctt_pkg::VER_ACCEPT;
        ps.commit_len = len;
    endtask

    task automatic drop_time();
        ps.verdict = ctt_pkg::VER_REJECT;
        ps.meridiem = ctt_pkg::MER_NONE;
    endtask

    // one look at a byte in the current phase; again means look once more
    task automatic step_phase(input logic [7:0] c, input logic [15:0] pos, output bit again);
        int idx;
        int g;
        int k;
        int a;
        bit tail;
        bit fail;
        logic [6:0] lim;
        logic [6:0] dig;
        int unsigned v;
        idx = phase_idx(ps.phase);
        again = 1'b0;
        fail = 1'b0;
        dig = 7'(c - 8'h30);
        if (idx < AP_BASE) begin
            g = idx / 4;
            k = idx % 4;
            lim = (g == 0) ? ctt_pkg::HOUR_LIM : ctt_pkg::MIN_LIM;
            case (k)
                0: if (!is_ws(c)) begin
                    if (c == "+" || c == "-") begin
                        ps.minus_seen = (c == "-");
                        ps.phase = ctt_pkg::t_phase'(ps.phase << 1);
                    end else if (is_digit(c)) begin
                        set_acc(g, dig);
                        ps.phase = ctt_pkg::t_phase'(ps.phase << 2);
                    end else drop_time();
                end
                1: if (is_digit(c)) begin
                    set_acc(g, dig);
                    ps.phase = ctt_pkg::t_phase'(ps.phase << 1);
                end else drop_time();
                2: if (is_digit(c)) begin
                    v = acc_of(g) * 10 + dig;
                    set_acc(g, (v > ctt_pkg::ACC_MAX) ? ctt_pkg::ACC_MAX : 7'(v));
                end else if ((ps.minus_seen && acc_of(g) != 7'd0) || acc_of(g) >= lim) begin
                    drop_time();
                end else if (g == 0) begin
                    ps.phase = ctt_pkg::PH_HOUR_POST;
                    again = 1'b1;
                end else if (g == 1) begin
                    ps.phase = ctt_pkg::PH_MIN_POST;
                    again = 1'b1;
                end else begin
                    // seconds set the length; an accepted suffix moves it on
                    ps.commit_len = pos;
                    if (ampm_hour()) begin
                        ps.phase = ctt_pkg::PH_TL_LEAD;
                        again = 1'b1;
                    end else take_time(pos);
                end
                default: if (!is_ws(c)) begin
                    if (g == 0) begin
                        if (c == ":") begin
                            ps.minus_seen = 1'b0;
                            ps.phase = ctt_pkg::PH_MIN_WS;
                        end else if (ampm_hour()) begin
                            ps.phase = ctt_pkg::PH_AP_LEAD;
                            again = 1'b1;
                        end else drop_time();
                    end else begin
                        // minutes keep the whitespace after them
                        ps.commit_len = pos;
                        if (c == ":") begin
                            ps.minus_seen = 1'b0;
                            ps.phase = ctt_pkg::PH_SEC_WS;
                        end else if (ampm_hour()) begin
                            ps.phase = ctt_pkg::PH_TL_LEAD;
                            again = 1'b1;
                        end else take_time(pos);
                    end
                end
            endcase
        end else begin
            // am/pm suffix; the tail form falls back to the time without it
            tail = (idx >= TL_BASE);
            a = idx - (tail ? TL_BASE : AP_BASE);
            case (a)
                0: if (!is_ws(c)) begin
                    if (c == "a" || c == "A") begin
                        ps.meridiem = ctt_pkg::MER_AM;
                        ps.phase = ctt_pkg::t_phase'(ps.phase << 1);
                    end else if (c == "p" || c == "P") begin
                        ps.meridiem = ctt_pkg::MER_PM;
                        ps.phase = ctt_pkg::t_phase'(ps.phase << 1);
                    end else fail = 1'b1;
                end
                1: if (c == END_BYTE) take_time(pos);
                else if (c == "m" || c == "M") ps.phase = ctt_pkg::t_phase'(ps.phase << 1);
                else fail = 1'b1;
                2: if (is_alpha(c)) begin
                    fail = 1'b1;
                end else begin
                    ps.phase = ctt_pkg::t_phase'(ps.phase << 1);
                    again = 1'b1;
                end
                default: if (!is_ws(c)) take_time(pos);
            endcase
            if (fail) begin
                ps.meridiem = ctt_pkg::MER_NONE;
                if (tail) take_time(ps.commit_len);
                else drop_time();
            end
        end
    endtask

    // parse one byte; a zero byte gives the time word and clears the parse
    task automatic parse_time_byte(input logic [7:0] c, output bit done,
                                   output ctt_pkg::t_result r);
        logic [15:0] pos;
        logic [6:0] h;
        bit again;
        int n;
        pos = ps.byte_count;
        for (n = 0; n < 8 && ps.verdict == ctt_pkg::VER_UNDECIDED; n++) begin
            step_phase(c, pos, again);
            if (!again) break;
        end
        if (ps.byte_count != ctt_pkg::LEN_MAX) ps.byte_count++;
        done = (c == END_BYTE);
        r = NO_TIME;
        if (done) begin
            if (ps.verdict == ctt_pkg::VER_ACCEPT) begin
                h = ps.hour_acc;
                if (ps.meridiem == ctt_pkg::MER_AM && h == ctt_pkg::NOON) h = 7'd0;
                else if (ps.meridiem == ctt_pkg::MER_PM && h != ctt_pkg::NOON)
                    h = h + ctt_pkg::NOON;
                r.ok = 1'b1;
                r.hour = h[ctt_pkg::HOUR_W-1:0];
                r.minute = ps.minute_acc[ctt_pkg::MIN_W-1:0];
                r.second = ps.second_acc[ctt_pkg::MIN_W-1:0];
                r.used_length = ps.commit_len;
            end
            ps = ctt_pkg::PARSE_RESET;
        end
    endtask

    function automatic ctt_pkg::t_result good_time(input int h, input int m, input int s,
                                                   input int len);
        ctt_pkg::t_result t;
        t.ok = 1'b1;
        t.hour = 5'(h);
        t.minute = 6'(m);
        t.second = 6'(s);
        t.used_length = 16'(len);
        return t;
    endfunction

    // idle length: mostly none, some short, a few long
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // text building
    task automatic put_str(input string s);
        int i;
        for (i = 0; i < s.len(); i++) txt.push_back(s[i]);
    endtask

    task automatic put_ws(input int n);
        repeat (n) begin
            if ($urandom_range(0, 1)) txt.push_back(8'd32);
            else txt.push_back(8'($urandom_range(9, 13)));
        end
    endtask

    task automatic put_field(input int lim);
        int v;
        int r;
        if ($urandom_range(0, 3) == 0) put_ws($urandom_range(1, 3));
        r = $urandom_range(0, 15);
        if (r == 0) v = $urandom_range(100, 999);
        else if (r < 3) v = $urandom_range(lim, 99);
        else v = $urandom_range(0, lim - 1);
        r = $urandom_range(0, 15);
        if (r == 0) begin
            put_str("+");
        end else if (r == 1) begin
            put_str("-");
            v = 0;
        end else if (r == 2) begin
            put_str("-");
        end
        if ($urandom_range(0, 9) == 0) put_str("00");
        if ($urandom_range(0, 2) == 0) put_str($sformatf("%02d", v));
        else put_str($sformatf("%0d", v));
    endtask

    task automatic put_suffix();
        if ($urandom_range(0, 1)) put_ws($urandom_range(1, 2));
        put_str(suffix_forms[$urandom_range(0, 11)]);
        if ($urandom_range(0, 2) == 0) put_ws($urandom_range(1, 2));
    endtask

    // random time string: mostly well formed, some noise and corruption
    task automatic gen_time_text();
        int form;
        int sel;
        txt.delete();
        sel = $urandom_range(0, 19);
        if (sel < 2) begin
            repeat ($urandom_range(1, 8)) txt.push_back(8'($urandom_range(1, 255)));
        end else begin
            form = $urandom_range(0, 3);
            put_field(24);
            if (form == 0) begin
                if ($urandom_range(0, 5) != 0) put_suffix();
            end else begin
                if ($urandom_range(0, 9) == 0) put_ws(1);
                put_str(":");
                put_field(60);
                if (form >= 2) begin
                    if ($urandom_range(0, 4) == 0) put_ws(1);
                    put_str(":");
                    put_field(60);
                end
                if ($urandom_range(0, 2) == 0) put_ws($urandom_range(1, 2));
                if ($urandom_range(0, 1)) put_suffix();
            end
            if ($urandom_range(0, 4) == 0)
                repeat ($urandom_range(1, 3)) txt.push_back(8'($urandom_range(1, 255)));
            if (sel == 2) txt[$urandom_range(0, txt.size() - 1)] = 8'($urandom_range(1, 255));
        end
    endtask

    // drive one byte word and wait until it is taken
    task automatic send_byte(input logic [7:0] c, input bit quick, output bit done,
                             output ctt_pkg::t_result r);
        int g;
        g = quick ? 0 : idle_len();
        if (g > 0) begin
            i_valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_ch <= c;
        do @(posedge i_clk); while (o_stall);
        parse_time_byte(c, done, r);
    endtask

    // send the text plus its zero byte and log the expected time word
    task automatic send_text(input int quick_n, input bit typed, input ctt_pkg::t_result want);
        bit done;
        bit calm;
        ctt_pkg::t_result r;
        int i;
        calm = ($urandom_range(0, 3) == 0);
        for (i = 0; i <= txt.size(); i++)
            send_byte((i < txt.size()) ? txt[i] : END_BYTE, calm || i < quick_n, done, r);
        pending_times.push_back(typed ? want : r);
    endtask

    // sender pause until every expected word is back
    task automatic drain();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending_times.size() != 0);
    endtask

    task automatic add_row(input string s, input int pad, input bit typed,
                           input ctt_pkg::t_result want);
        t_dir_row row;
        row.text = s;
        row.pad = pad;
        row.typed = typed;
        row.want = want;
        dir_rows.push_back(row);
    endtask

    // result side: random stalls, calm stretches and one long hold-off
    initial begin
        int hold_left;
        int calm_left;
        int busy_left;
        hold_left = 0;
        calm_left = 0;
        busy_left = 0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else if (calm_left > 0) begin
                calm_left--;
                i_stall <= 1'b0;
            end else if (busy_left > 0) begin
                busy_left--;
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
                if ($urandom_range(0, 4) == 0) calm_left = $urandom_range(10, 60);
                else busy_left = idle_len();
            end
        end
    end

    // compare each result word with the oldest expected time
    task automatic check_field(input string what, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $display("%0t: %s expected %0d actual %0d", $time, what, want, got);
            mismatch_cnt++;
        end
    endtask

    always @(posedge i_clk) begin
        ctt_pkg::t_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_times.size() == 0) begin
                $display({"%0t: result word with nothing pending, expected none",
                          " actual ok=%0d %0d:%0d:%0d len %0d"},
                         $time, o_ok, o_hour, o_minute, o_second, o_used_length);
                mismatch_cnt++;
            end else begin
                want = pending_times.pop_front();
                check_field("ok", want.ok, o_ok);
                check_field("hour", want.hour, o_hour);
                check_field("minute", want.minute, o_minute);
                check_field("second", want.second, o_second);
                check_field("used_length", want.used_length, o_used_length);
            end
        end
    end

    // stimulus
    initial begin
        int rand_bytes;
        bit paused;
        rand_bytes = 0;
        paused = 1'b0;

        // directed rows; typed times where the answer is plain
        add_row("", 0, 1, NO_TIME);
        add_row("0:00", 0, 1, good_time(0, 0, 0, 4));
        add_row("23:59:59", 0, 1, good_time(23, 59, 59, 8));
        add_row("24:00", 0, 1, NO_TIME);
        add_row("12:60", 0, 1, NO_TIME);
        add_row("1:2:60", 0, 1, NO_TIME);
        add_row("12am", 0, 1, good_time(0, 0, 0, 4));
        add_row("12pm", 0, 1, good_time(12, 0, 0, 4));
        add_row("  +7:05 pm  x", 0, 0, NO_TIME);
        add_row("11:30 p", 0, 0, NO_TIME);
        add_row("11:30 p x", 0, 0, NO_TIME);
        add_row("7 pmx", 0, 1, NO_TIME);
        add_row("7 a", 0, 0, NO_TIME);
        add_row("-0:-00:+0", 0, 0, NO_TIME);
        add_row("-1:00", 0, 1, NO_TIME);
        add_row("999:00", 0, 1, NO_TIME);
        add_row("\011\012\013\014\015 5:5", 0, 0, NO_TIME);
        add_row("13pm", 0, 1, NO_TIME);
        add_row("\200\377", 0, 1, NO_TIME);
        add_row("12:00:00 am junk", 0, 0, NO_TIME);
        add_row("0am", 0, 1, NO_TIME);
        add_row("5:07AM\tQ", 0, 0, NO_TIME);
        add_row("+:1", 0, 1, NO_TIME);
        add_row("1:02", 3, 1, good_time(1, 2, 0, 7));
        add_row("10:20:30 P.M.", 0, 0, NO_TIME);

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[n]) begin
            txt.delete();
            repeat (dir_rows[n].pad) txt.push_back(8'd32);
            put_str(dir_rows[n].text);
            send_text(dir_rows[n].pad, dir_rows[n].typed, dir_rows[n].want);
        end
        drain();

        // random strings; the result side holds off at the start
        hold_req = 1'b1;
        while (rand_bytes < RAND_BYTES) begin
            gen_time_text();
            rand_bytes += txt.size() + 1;
            send_text(0, 1'b0, NO_TIME);
            if (!paused && rand_bytes > RAND_BYTES / 2) begin
                paused = 1'b1;
                drain();
            end
        end

        drain();
        repeat (8) @(posedge i_clk);
        if (mismatch_cnt == 0) $display("SCOREBOARD CLEAN");
        else $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
